// ----- design/assert_macros.svh -----
// Assertion macros shared by the echelon basis design.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gf2eb_pkg.sv -----
// Shared types and constants for the GF(2) echelon basis.
// Used by the sequencer and the top level; depends on nothing.
package gf2eb_pkg;

    localparam int VEC_BITS_DEF = 64;
    localparam int VEC_W        = 64;
    localparam int RANK_W       = 7;
    localparam int CMD_W        = 2;
    localparam int OUT_TDATA_W  = 16;
    localparam logic [RANK_W-1:0] ACTIVE_ROWS_RST = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EVAL,
        ST_BACK,
        ST_APPEND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              added;
        logic              in_span;
    } res_t;

endpackage

// ----- design/gf2eb_row_mem.sv -----
// Basis row store: one write port, one registered read port.
// Each word holds a pivot index above the row bits; no package needed.
module gf2eb_row_mem #(
    parameter int WIDTH = 70,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/gf2eb_seq.sv -----
// Command sequencer: reduce pass, pivot pick, back-reduce pass and append.
// Uses gf2eb_pkg; drives the row store in gf2eb_row_mem.
module gf2eb_seq #(
    parameter int VEC_BITS = gf2eb_pkg::VEC_BITS_DEF,
    parameter int AW       = $clog2(VEC_BITS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  gf2eb_pkg::cmd_t               cmd,
    input  logic [VEC_BITS-1:0]           vec,
    input  logic [gf2eb_pkg::RANK_W-1:0]  active_rows,
    output logic                          idle,
    input  logic                          res_free,
    output logic                          res_valid,
    output gf2eb_pkg::res_t               res,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    input  logic [VEC_BITS+AW-1:0]        mem_rdata,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [VEC_BITS+AW-1:0]        mem_wdata
);

    localparam int RW = gf2eb_pkg::RANK_W;

    gf2eb_pkg::state_t state_reg, state_next;
    gf2eb_pkg::cmd_t   cmd_reg, cmd_next;
    logic [VEC_BITS-1:0] x_reg, x_next;
    logic [RW-1:0]       cnt_reg, cnt_next;
    logic [RW-1:0]       rank_reg, rank_next;
    logic                dv_reg, dv_next;
    logic [AW-1:0]       wa_reg, wa_next;
    logic [AW-1:0]       p_reg, p_next;
    logic                span_reg, span_next;
    logic                added_reg, added_next;

    logic [VEC_BITS-1:0] rd_row;
    logic [AW-1:0]       rd_piv;
    logic [AW-1:0]       low;
    logic                x_zero;
    logic                issue;
    logic                pass_done;
    logic                can_add;

    assign rd_row    = mem_rdata[VEC_BITS-1:0];
    assign rd_piv    = mem_rdata[VEC_BITS +: AW];
    assign x_zero    = (x_reg == '0);
    assign issue     = (cnt_reg < rank_reg);
    assign pass_done = (cnt_reg == rank_reg);
    assign can_add   = !x_zero && (RW'(low) < active_rows)
                       && (rank_reg < RW'(VEC_BITS));

    always_comb begin
        low = '0;
        for (int i = VEC_BITS - 1; i >= 0; i--) begin
            if (x_reg[i]) begin
                low = AW'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gf2eb_pkg::ST_IDLE: begin
                if (start) begin
                    if (cmd inside {gf2eb_pkg::CMD_INSERT, gf2eb_pkg::CMD_QUERY}) begin
                        state_next = gf2eb_pkg::ST_REDUCE;
                    end else begin
                        state_next = gf2eb_pkg::ST_OUT;
                    end
                end
            end
            gf2eb_pkg::ST_REDUCE: begin
                if (pass_done) begin
                    state_next = gf2eb_pkg::ST_EVAL;
                end
            end
            gf2eb_pkg::ST_EVAL: begin
                if (cmd_reg == gf2eb_pkg::CMD_INSERT && can_add) begin
                    state_next = gf2eb_pkg::ST_BACK;
                end else begin
                    state_next = gf2eb_pkg::ST_OUT;
                end
            end
            gf2eb_pkg::ST_BACK: begin
                if (pass_done) begin
                    state_next = gf2eb_pkg::ST_APPEND;
                end
            end
            gf2eb_pkg::ST_APPEND: begin
                state_next = gf2eb_pkg::ST_OUT;
            end
            gf2eb_pkg::ST_OUT: begin
                if (res_free) begin
                    state_next = gf2eb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gf2eb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_next   = cmd_reg;
        x_next     = x_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        dv_next    = 1'b0;
        wa_next    = wa_reg;
        p_next     = p_reg;
        span_next  = span_reg;
        added_next = added_reg;
        idle       = 1'b0;
        res_valid  = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = cnt_reg[AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = wa_reg;
        mem_wdata  = {rd_piv, rd_row ^ x_reg};
        case (state_reg)
            gf2eb_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    cmd_next   = cmd;
                    x_next     = vec;
                    cnt_next   = '0;
                    span_next  = 1'b0;
                    added_next = 1'b0;
                    if (cmd == gf2eb_pkg::CMD_CLEAR) begin
                        rank_next = '0;
                    end
                end
            end
            gf2eb_pkg::ST_REDUCE: begin
                if (issue) begin
                    mem_re   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    dv_next  = 1'b1;
                end
                if (dv_reg && x_reg[rd_piv]) begin
                    x_next = x_reg ^ rd_row;
                end
            end
            gf2eb_pkg::ST_EVAL: begin
                cnt_next = '0;
                p_next   = low;
                if (cmd_reg == gf2eb_pkg::CMD_QUERY) begin
                    span_next = x_zero;
                end
            end
            gf2eb_pkg::ST_BACK: begin
                if (issue) begin
                    mem_re   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    dv_next  = 1'b1;
                    wa_next  = cnt_reg[AW-1:0];
                end
                if (dv_reg && rd_row[p_reg]) begin
                    mem_we = 1'b1;
                end
            end
            gf2eb_pkg::ST_APPEND: begin
                mem_we     = 1'b1;
                mem_waddr  = rank_reg[AW-1:0];
                mem_wdata  = {p_reg, x_reg};
                rank_next  = rank_reg + 1'b1;
                added_next = 1'b1;
            end
            gf2eb_pkg::ST_OUT: begin
                res_valid = res_free;
            end
            default: begin
            end
        endcase
    end

    assign res.in_span = span_reg;
    assign res.added   = added_reg;
    assign res.rank    = rank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gf2eb_pkg::ST_IDLE;
            rank_reg  <= '0;
            dv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rank_reg  <= rank_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        cnt_reg   <= cnt_next;
        wa_reg    <= wa_next;
        p_reg     <= p_next;
        span_reg  <= span_next;
        added_reg <= added_next;
    end

endmodule

// ----- design/gf2_incremental_echelon_basis.sv -----
// Channel   Dir  Fields
// s_        in   tuser: cmd[1:0]; tdata: vec[63:0]
// m_        out  tdata: in_span[0], added[1], rank[8:2], zero pad above
// cfg_      in   cfg_wdata: active_rows[6:0], written when cfg_we is high
// Query and insert run a reduce pass; insert may then back-reduce and append a row.
// Each pass walks the stored rows through the single read port, one row per cycle.
// One transaction is in work at a time; s_tready is low until its result is registered.
// A stalled m_ side holds the finished result in the sequencer until the output frees.
// Synchronous active-low reset empties the basis and sets active_rows to 64.
// Top level of the GF(2) echelon basis; uses gf2eb_pkg, gf2eb_seq, gf2eb_row_mem
// and assert_macros.svh.
`include "assert_macros.svh"

module gf2_incremental_echelon_basis #(
    parameter int VEC_BITS = gf2eb_pkg::VEC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [gf2eb_pkg::RANK_W-1:0]       cfg_wdata,   // active_rows
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gf2eb_pkg::VEC_W-1:0]        s_tdata,     // vec
    input  logic [gf2eb_pkg::CMD_W-1:0]        s_tuser,     // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gf2eb_pkg::OUT_TDATA_W-1:0]  m_tdata      // in_span, added, rank
);

    localparam int AW = $clog2(VEC_BITS);
    localparam int MW = VEC_BITS + AW;
    localparam int RESW = $bits(gf2eb_pkg::res_t);

    logic [gf2eb_pkg::RANK_W-1:0] active_rows_reg;
    logic            m_tvalid_reg, m_tvalid_next;
    gf2eb_pkg::res_t m_res_reg, m_res_next;

    logic            s_accept;
    logic            seq_idle;
    logic            res_free;
    logic            seq_res_valid;
    gf2eb_pkg::res_t seq_res;
    logic            res_two_flags;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [MW-1:0]   mem_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [MW-1:0]   mem_wdata;

    assign s_tready = seq_idle;
    assign s_accept = s_tvalid && s_tready;
    assign res_free = !m_tvalid_reg || m_tready;

    gf2eb_seq #(
        .VEC_BITS (VEC_BITS),
        .AW       (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_accept),
        .cmd         (gf2eb_pkg::cmd_t'(s_tuser)),
        .vec         (s_tdata[VEC_BITS-1:0]),
        .active_rows (active_rows_reg),
        .idle        (seq_idle),
        .res_free    (res_free),
        .res_valid   (seq_res_valid),
        .res         (seq_res),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata)
    );

    gf2eb_row_mem #(
        .WIDTH (MW),
        .DEPTH (VEC_BITS),
        .AW    (AW)
    ) u_row_mem (
        .aclk  (aclk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (seq_res_valid) begin
            m_tvalid_next = 1'b1;
            m_res_next    = seq_res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rows_reg <= gf2eb_pkg::ACTIVE_ROWS_RST;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                active_rows_reg <= cfg_wdata;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(gf2eb_pkg::OUT_TDATA_W - RESW){1'b0}}, m_res_reg};

    assign res_two_flags = seq_res.in_span && seq_res.added;

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready, "not busy")
    `ASSERT_SAME(a_no_result_when_idle, aclk, aresetn, s_tready, !seq_res_valid, "idle result")
    `ASSERT_SAME(a_single_flag, aclk, aresetn, seq_res_valid, !res_two_flags, "both flags set")
    `ASSERT_NEXT(a_result_registered, aclk, aresetn, seq_res_valid, m_tvalid, "no output load")

endmodule

// ----- tb/tb_gf2_incremental_echelon_basis.sv -----
// Self-checking bench for gf2_incremental_echelon_basis: streams clear, insert, query and
// no-op transactions and checks each result against an in-bench echelon basis tracker.
// Depends on gf2eb_pkg and the gf2_incremental_echelon_basis RTL.
module tb_gf2_incremental_echelon_basis;
    import gf2eb_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int IDLE_PCT       = 35;
    localparam int TAIL_CYCLES    = 140;
    localparam int MAX_ROWS       = 64;

    typedef struct {
        cmd_t             cmd;
        logic [VEC_W-1:0] vec;
    } basis_op_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [RANK_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [VEC_W-1:0]       s_tdata   = '0;   // vec[63:0]
    logic [CMD_W-1:0]       s_tuser   = '0;   // cmd[1:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // in_span[0], added[1], rank[8:2], zero pad

    // basis tracker
    logic [VEC_W-1:0]  row_bits  [MAX_ROWS];
    logic [5:0]        row_pivot [MAX_ROWS];
    int unsigned       row_count   = 0;
    logic [RANK_W-1:0] pivot_limit = ACTIVE_ROWS_RST;

    basis_op_t        pending_ops[$];
    res_t             expected_results[$];
    logic [VEC_W-1:0] fed_vecs[$];
    int               ops_sent     = 0;
    int               results_seen = 0;
    int               fail_count   = 0;
    int               cycle_count  = 0;
    int               holdoff_req  = 0;
    int               holdoff_ack  = 0;
    int               holdoff_left = 0;
    logic             calm         = 1'b0;

    gf2_incremental_echelon_basis dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [VEC_W-1:0] reduce_by_basis(logic [VEC_W-1:0] v);
        int i;
        for (i = 0; i < row_count; i++) begin
            if (v[row_pivot[i]])
                v ^= row_bits[i];
        end
        return v;
    endfunction

    function automatic res_t track_basis_op(basis_op_t op);
        res_t             r;
        logic [VEC_W-1:0] t;
        int               p;
        int               i;
        r = '0;
        case (op.cmd)
            CMD_CLEAR: row_count = 0;
            CMD_INSERT: begin
                t = reduce_by_basis(op.vec);
                if (t != '0) begin
                    p = 0;
                    while (!t[p])
                        p++;
                    if (p < pivot_limit && row_count < MAX_ROWS) begin
                        for (i = 0; i < row_count; i++) begin
                            if (row_bits[i][p])
                                row_bits[i] ^= t;
                        end
                        row_bits[row_count]  = t;
                        row_pivot[row_count] = p[5:0];
                        row_count++;
                        r.added = 1'b1;
                    end
                end
            end
            CMD_QUERY: r.in_span = (reduce_by_basis(op.vec) == '0);
            default: ;
        endcase
        r.rank = row_count[RANK_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        basis_op_t op;
        logic      taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            taken = s_tvalid && s_tready;
            if (taken) begin
                op.cmd = cmd_t'(s_tuser);
                op.vec = s_tdata;
                expected_results.push_back(track_basis_op(op));
            end
            if (!s_tvalid || taken) begin
                if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    op = pending_ops.pop_front();
                    s_tuser  <= op.cmd;
                    s_tdata  <= op.vec;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t exp_res;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata[0] !== exp_res.in_span) begin
                        $display("%0t: in_span expected %0b actual %0b",
                                 $time, exp_res.in_span, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[1] !== exp_res.added) begin
                        $display("%0t: added expected %0b actual %0b",
                                 $time, exp_res.added, m_tdata[1]);
                        fail_count++;
                    end
                    if (m_tdata[8:2] !== exp_res.rank) begin
                        $display("%0t: rank expected %0d actual %0d",
                                 $time, exp_res.rank, m_tdata[8:2]);
                        fail_count++;
                    end
                end
            end
            if (holdoff_req != holdoff_ack) begin
                holdoff_ack  = holdoff_req;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** gf2_incremental_echelon_basis: FAILED **");
            $finish;
        end
    end

    function automatic void push_op(cmd_t cmd, logic [VEC_W-1:0] vec);
        basis_op_t op;
        op.cmd = cmd;
        op.vec = vec;
        pending_ops.push_back(op);
        ops_sent++;
        if (cmd == CMD_INSERT)
            fed_vecs.push_back(vec);
        else if (cmd == CMD_CLEAR)
            fed_vecs.delete();
    endfunction

    function automatic logic [VEC_W-1:0] draw_vec();
        logic [VEC_W-1:0] v;
        int               kind;
        kind = $urandom_range(9);
        v = {$urandom, $urandom};
        case (kind)
            3: v = 64'd1 << $urandom_range(63);
            4: v = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63))
                   | (64'd1 << $urandom_range(63));
            5: v = v & (~64'd0 << $urandom_range(63));
            6, 7, 8: begin
                if (fed_vecs.size() > 0) begin
                    v = '0;
                    repeat ($urandom_range(1, 4))
                        v ^= fed_vecs[$urandom_range(fed_vecs.size() - 1)];
                end
            end
            9: v = $urandom_range(1) ? '0 : '1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic run_burst(int n);
        int roll;
        push_op(CMD_CLEAR, draw_vec());
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 55)
                push_op(CMD_INSERT, draw_vec());
            else if (roll < 87)
                push_op(CMD_QUERY, draw_vec());
            else if (roll < 94)
                push_op(CMD_NOP, draw_vec());
            else
                push_op(CMD_CLEAR, draw_vec());
        end
    endtask

    task automatic fill_basis(int n);
        push_op(CMD_CLEAR, '0);
        repeat (n)
            push_op(CMD_INSERT, {$urandom, $urandom});
        repeat (8)
            push_op(CMD_QUERY, draw_vec());
    endtask

    task automatic drain();
        wait (results_seen == ops_sent);
    endtask

    task automatic set_pivot_limit(logic [RANK_W-1:0] value);
        drain();
        @(posedge aclk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        pivot_limit  = value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        set_pivot_limit(7'd64);
        push_op(CMD_NOP,    '1);
        push_op(CMD_QUERY,  '0);
        push_op(CMD_QUERY,  '1);
        push_op(CMD_INSERT, '0);
        push_op(CMD_INSERT, '1);
        push_op(CMD_INSERT, 64'h8000_0000_0000_0000);
        push_op(CMD_INSERT, 64'h8000_0000_0000_0001);
        push_op(CMD_QUERY,  64'h7FFF_FFFF_FFFF_FFFF);
        push_op(CMD_INSERT, 64'h0000_0000_0000_0002);
        push_op(CMD_QUERY,  64'h5555_5555_5555_5555);
        push_op(CMD_NOP,    '0);
        push_op(CMD_CLEAR,  '1);
        push_op(CMD_QUERY,  '1);
        push_op(CMD_INSERT, 64'h8000_0000_0000_0000);

        set_pivot_limit(7'd1);
        push_op(CMD_CLEAR,  '0);
        push_op(CMD_INSERT, 64'h0000_0000_0000_0020);
        push_op(CMD_INSERT, 64'h0000_0000_0000_0001);
        push_op(CMD_INSERT, 64'h0000_0000_0000_0003);
        push_op(CMD_QUERY,  64'h0000_0000_0000_0001);

        set_pivot_limit(7'd0);
        push_op(CMD_INSERT, 64'h0000_0000_0000_0001);
        push_op(CMD_INSERT, 64'h0000_0000_0000_0002);

        set_pivot_limit(7'd127);
        push_op(CMD_INSERT, 64'h8000_0000_0000_0000);
        push_op(CMD_QUERY,  64'h8000_0000_0000_0001);

        // long stretch with both sides always ready
        set_pivot_limit(7'd64);
        calm = 1'b1;
        fill_basis(70);
        drain();
        calm = 1'b0;

        // hold off the result side while the sender keeps offering
        set_pivot_limit(7'd127);
        run_burst(70);
        holdoff_req++;

        set_pivot_limit(7'd8);
        run_burst(70);
        set_pivot_limit(7'd1);
        run_burst(40);
        set_pivot_limit(7'd0);
        run_burst(30);
        set_pivot_limit(7'd33);
        run_burst(70);
        set_pivot_limit(7'd127);
        fill_basis(70);
        set_pivot_limit(7'd17);
        run_burst(70);
        set_pivot_limit(7'd64);
        run_burst(80);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("** gf2_incremental_echelon_basis: PASSED **");
        end else begin
            $display("** gf2_incremental_echelon_basis: FAILED **");
        end
        $finish;
    end

endmodule
